@@ rtl/tme_pkg.sv @@
// ----------------------------------------------------------------------------
// tme_pkg
// shared types and constants of the thermal matrix estimator
// ----------------------------------------------------------------------------
package tme_pkg;

	// default grid size
	localparam int GRID_X_DEF = 4;
	localparam int GRID_Y_DEF = 4;

	// command address width, covers the largest decay matrix (208 x 208)
	localparam int CMD_AW = 16;
	localparam int COEF_W = 48;
	localparam int TEMP_W = 32;

	// accumulator width, holds 208 products of 48 x 33 bits
	localparam int ACC_W = 88;

	// apb register indexes
	localparam int PADDR_W = 4;
	localparam logic [1:0] REG_AMBIENT = 2'd0;
	localparam logic [1:0] REG_MASTER = 2'd1;
	localparam logic [1:0] REG_KIND = 2'd2;

	localparam logic [15:0] AMBIENT_RST = 16'd31815;
	localparam logic [15:0] MASTER_RST = 16'd0;
	localparam logic [7:0] KIND_RST = 8'h55;

	// floor(n / 25) as (n * AMB_RECIP) >> AMB_SHIFT, exact for n < 2^30
	localparam logic [30:0] AMB_RECIP = 31'd1374389535;
	localparam int AMB_SHIFT = 35;

	// 313.15 kelvin in q16.16
	localparam logic [31:0] NODE_RESET = 32'd20522598;

	localparam logic [3:0] FLIT_CLR = 4'd2;
	localparam logic [3:0] FLIT_SRC = 4'd4;
	localparam logic [3:0] FLIT_PWR = 4'd5;
	localparam logic [3:0] FLIT_END = 4'd13;

	localparam int HDR_WORDS = 13;

	typedef enum logic [1:0] {
		FUNC_FLIT,
		FUNC_STEADY,
		FUNC_DECAY,
		FUNC_NONE
	} func_t;

	typedef enum logic [1:0] {
		OP_NONE,
		OP_STEADY,
		OP_DECAY,
		OP_POWER
	} op_t;

	typedef struct packed {
		op_t op;
		logic compute;
		logic [CMD_AW-1:0] addr;
		logic [COEF_W-1:0] data;
	} cmd_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_STEADY,
		ST_SDRAIN,
		ST_DIFF,
		ST_DIFFEND,
		ST_DECAY,
		ST_DDRAIN,
		ST_EMIT
	} state_t;

endpackage

@@ rtl/tme_ram.sv @@
// ----------------------------------------------------------------------------
// tme_ram
// generic simple dual port ram with registered read
// ----------------------------------------------------------------------------
module tme_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

@@ rtl/tme_queue.sv @@
// ----------------------------------------------------------------------------
// tme_queue
// two entry command queue between front and back
// ----------------------------------------------------------------------------
module tme_queue (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  tme_pkg::cmd_t  push_cmd,
	input  logic           pop,
	output tme_pkg::cmd_t  head,
	output logic           nonempty,
	output logic           full
);

	tme_pkg::cmd_t ent_q [2];
	logic          wr_q;
	logic          rd_q;
	logic [1:0]    cnt_q;

	assign head     = ent_q[rd_q];
	assign nonempty = (cnt_q != 2'd0);
	assign full     = (cnt_q == 2'd2);

	always_ff @(posedge clk) begin
		if (push) begin
			ent_q[wr_q] <= push_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= 1'b0;
			rd_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) begin
				wr_q <= ~wr_q;
			end
			if (pop) begin
				rd_q <= ~rd_q;
			end
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
		end
	end

endmodule

@@ rtl/tme_front.sv @@
// ----------------------------------------------------------------------------
// tme_front
// flit tracking and command classification
// ----------------------------------------------------------------------------
module tme_front #(
	parameter int GRID_X = tme_pkg::GRID_X_DEF,
	parameter int GRID_Y = tme_pkg::GRID_Y_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                accept,
	input  logic [1:0]          func,
	input  logic [31:0]         flit_word,
	input  logic [7:0]          coeff_row,
	input  logic [7:0]          coeff_col,
	input  logic signed [47:0]  coeff_value,
	output logic                push,
	output tme_pkg::cmd_t       cmd
);

	localparam int CELLS  = GRID_X * GRID_Y;
	localparam int NODES  = 4 * CELLS + 12;
	localparam int CELL_AW = (CELLS > 1) ? $clog2(CELLS) : 1;

	logic [3:0]       flit_count_q, flit_count_n, cnt_inc;
	logic [7:0]       src_x_q, src_x_n;
	logic [7:0]       src_y_q, src_y_n;
	logic [CELLS-1:0] rep_q, rep_n;
	logic             first_q, first_n;
	logic [CELL_AW-1:0] cell_idx;

	assign cnt_inc  = flit_count_q + 4'd1;
	assign cell_idx = CELL_AW'(32'(src_y_q) * GRID_X + 32'(src_x_q));

	always_comb begin
		flit_count_n = flit_count_q;
		src_x_n      = src_x_q;
		src_y_n      = src_y_q;
		rep_n        = rep_q;
		first_n      = first_q;
		cmd.op       = tme_pkg::OP_NONE;
		cmd.compute  = 1'b0;
		cmd.addr     = '0;
		cmd.data     = coeff_value;
		if (accept) begin
			case (func)
				tme_pkg::FUNC_STEADY: begin
					if (32'(coeff_row) < NODES && 32'(coeff_col) < CELLS) begin
						cmd.op   = tme_pkg::OP_STEADY;
						cmd.addr = tme_pkg::CMD_AW'(32'(coeff_row) * CELLS + 32'(coeff_col));
					end
				end
				tme_pkg::FUNC_DECAY: begin
					if (32'(coeff_row) < NODES && 32'(coeff_col) < NODES) begin
						cmd.op   = tme_pkg::OP_DECAY;
						cmd.addr = tme_pkg::CMD_AW'(32'(coeff_row) * NODES + 32'(coeff_col));
					end
				end
				tme_pkg::FUNC_FLIT: begin
					flit_count_n = cnt_inc;
					if (cnt_inc == tme_pkg::FLIT_CLR) begin
						src_x_n = 8'd0;
						src_y_n = 8'd0;
					end else if (cnt_inc == tme_pkg::FLIT_SRC) begin
						src_x_n = flit_word[15:8];
						src_y_n = flit_word[7:0];
					end else if (cnt_inc == tme_pkg::FLIT_PWR) begin
						if (32'(src_x_q) < GRID_X && 32'(src_y_q) < GRID_Y) begin
							rep_n[cell_idx] = 1'b1;
							cmd.op   = tme_pkg::OP_POWER;
							cmd.addr = tme_pkg::CMD_AW'(cell_idx);
							cmd.data = {16'd0, flit_word};
						end
					end else if (cnt_inc >= tme_pkg::FLIT_END) begin
						flit_count_n = 4'd0;
					end
					// every cell reported: the first full set only arms
					if (&rep_n) begin
						if (!first_q) begin
							first_n = 1'b1;
						end else begin
							rep_n       = '0;
							src_x_n     = 8'd0;
							src_y_n     = 8'd0;
							cmd.compute = 1'b1;
						end
					end
				end
				default: begin
				end
			endcase
		end
		push = (cmd.op != tme_pkg::OP_NONE) || cmd.compute;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			flit_count_q <= 4'd0;
			src_x_q      <= 8'd0;
			src_y_q      <= 8'd0;
			rep_q        <= '0;
			first_q      <= 1'b0;
		end else begin
			flit_count_q <= flit_count_n;
			src_x_q      <= src_x_n;
			src_y_q      <= src_y_n;
			rep_q        <= rep_n;
			first_q      <= first_n;
		end
	end

endmodule

@@ rtl/tme_back.sv @@
// ----------------------------------------------------------------------------
// tme_back
// command execution, shared mac engine and packet emission
// ----------------------------------------------------------------------------
module tme_back #(
	parameter int GRID_X = tme_pkg::GRID_X_DEF,
	parameter int GRID_Y = tme_pkg::GRID_Y_DEF
) (
	input  logic           clk,
	input  logic           arst_n,
	input  tme_pkg::cmd_t  head,
	input  logic           nonempty,
	output logic           pop,
	input  logic [15:0]    ambient,
	input  logic [15:0]    master_address,
	input  logic [7:0]     packet_kind,
	output logic           word_strobe,
	output logic [31:0]    packet_word,
	output logic           last_word
);

	localparam int CELLS   = GRID_X * GRID_Y;
	localparam int NODES   = 4 * CELLS + 12;
	localparam int PKT     = CELLS + tme_pkg::HDR_WORDS;
	localparam int CELL_AW = (CELLS > 1) ? $clog2(CELLS) : 1;
	localparam int NODE_AW = $clog2(NODES);
	localparam int SC_AW   = $clog2(NODES * CELLS);
	localparam int DC_AW   = $clog2(NODES * NODES);
	localparam int PKT_W   = $clog2(PKT);
	localparam int ACC_W   = tme_pkg::ACC_W;

	function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
		logic signed [31:0] r;
		if (v > 64'sd2147483647) begin
			r = 32'sh7FFFFFFF;
		end else if (v < -64'sd2147483648) begin
			r = 32'sh80000000;
		end else begin
			r = v[31:0];
		end
		return r;
	endfunction

	tme_pkg::state_t state_q, state_n;

	logic [NODE_AW-1:0] i_q, j_q;
	logic [DC_AW-1:0]   caddr_q;
	logic [PKT_W-1:0]   w_q;

	// ram ports
	logic                pw_we, sc_we, dc_we, st_we, df_we, nd_we;
	logic [31:0]         pw_rd, st_rd, df_rd, nd_rd;
	logic [47:0]         sc_rd, dc_rd;
	logic [31:0]         st_wd, df_wd, nd_wd;
	logic [NODE_AW-1:0]  st_ra, nd_ra, st_wa, nd_wa;
	logic [NODE_AW-1:0]  nd_ra_s1;
	logic [NODES-1:0]    nd_vld_q;

	// issue controls
	logic iss_v, iss_first, iss_last, iss_dec, row_end, pass_end;
	logic dif_v, emit_v;

	// mac pipeline
	logic               v_s1, first_s1, last_s1, dec_s1;
	logic [NODE_AW-1:0] row_s1;
	logic               v_s2, first_s2, last_s2, dec_s2;
	logic [NODE_AW-1:0] row_s2;
	logic               v_s3, first_s3, last_s3, dec_s3;
	logic [NODE_AW-1:0] row_s3;
	logic signed [64:0] plo_s2, phi_s2;
	logic signed [ACC_W-1:0] prod_s3, acc_q, acc_sum;
	logic signed [47:0] coef;
	logic signed [32:0] opnd;

	logic               fin1_q, dec_f1_q, fin2_q, dec_f2_q;
	logic [NODE_AW-1:0] row_f1_q, row_f2_q;
	logic signed [ACC_W-1:0] res_f1_q, res_f2_q;

	logic               dv_s1, ev_s1;
	logic [NODE_AW-1:0] dj_s1;
	logic [PKT_W-1:0]   w_s1;
	logic [PKT_W-1:0]   w_sub;

	logic [60:0]        amb_prod_q;
	logic signed [33:0] amb;
	logic signed [31:0] node_val, steady_fl, decay_fl;
	logic signed [39:0] centi_q, centi_r;
	logic [31:0]        word_n;
	logic               pipe_busy;

	assign amb      = 34'(amb_prod_q[60:tme_pkg::AMB_SHIFT]);
	assign node_val = nd_vld_q[nd_ra_s1] ? nd_rd : tme_pkg::NODE_RESET;
	assign pipe_busy = v_s1 | v_s2 | v_s3 | fin1_q | fin2_q;
	assign row_end  = iss_dec ? (j_q == NODE_AW'(NODES - 1)) : (j_q == NODE_AW'(CELLS - 1));
	assign pass_end = row_end && (i_q == NODE_AW'(NODES - 1));
	assign w_sub    = w_q - PKT_W'(tme_pkg::HDR_WORDS);

	tme_ram #(.WIDTH(32), .DEPTH(CELLS)) u_power (
		.clk(clk), .we(pw_we), .waddr(head.addr[CELL_AW-1:0]), .wdata(head.data[31:0]),
		.raddr(j_q[CELL_AW-1:0]), .rdata(pw_rd)
	);
	tme_ram #(.WIDTH(48), .DEPTH(NODES * CELLS)) u_scoef (
		.clk(clk), .we(sc_we), .waddr(head.addr[SC_AW-1:0]), .wdata(head.data),
		.raddr(caddr_q[SC_AW-1:0]), .rdata(sc_rd)
	);
	tme_ram #(.WIDTH(48), .DEPTH(NODES * NODES)) u_dcoef (
		.clk(clk), .we(dc_we), .waddr(head.addr[DC_AW-1:0]), .wdata(head.data),
		.raddr(caddr_q), .rdata(dc_rd)
	);
	tme_ram #(.WIDTH(32), .DEPTH(NODES)) u_steady (
		.clk(clk), .we(st_we), .waddr(st_wa), .wdata(st_wd),
		.raddr(st_ra), .rdata(st_rd)
	);
	tme_ram #(.WIDTH(32), .DEPTH(NODES)) u_diff (
		.clk(clk), .we(df_we), .waddr(dj_s1), .wdata(df_wd),
		.raddr(j_q), .rdata(df_rd)
	);
	tme_ram #(.WIDTH(32), .DEPTH(NODES)) u_node (
		.clk(clk), .we(nd_we), .waddr(nd_wa), .wdata(nd_wd),
		.raddr(nd_ra), .rdata(nd_rd)
	);

	// next state
	always_comb begin
		state_n = state_q;
		unique case (state_q)
			tme_pkg::ST_IDLE: begin
				if (nonempty && head.compute) begin
					state_n = tme_pkg::ST_STEADY;
				end
			end
			tme_pkg::ST_STEADY: begin
				if (pass_end) begin
					state_n = tme_pkg::ST_SDRAIN;
				end
			end
			tme_pkg::ST_SDRAIN: begin
				if (!pipe_busy) begin
					state_n = tme_pkg::ST_DIFF;
				end
			end
			tme_pkg::ST_DIFF: begin
				if (j_q == NODE_AW'(NODES - 1)) begin
					state_n = tme_pkg::ST_DIFFEND;
				end
			end
			tme_pkg::ST_DIFFEND: state_n = tme_pkg::ST_DECAY;
			tme_pkg::ST_DECAY: begin
				if (pass_end) begin
					state_n = tme_pkg::ST_DDRAIN;
				end
			end
			tme_pkg::ST_DDRAIN: begin
				if (!pipe_busy) begin
					state_n = tme_pkg::ST_EMIT;
				end
			end
			tme_pkg::ST_EMIT: begin
				if (w_q == PKT_W'(PKT - 1)) begin
					state_n = tme_pkg::ST_IDLE;
				end
			end
			default: state_n = tme_pkg::ST_IDLE;
		endcase
	end

	// outputs of the state machine
	always_comb begin
		pop     = 1'b0;
		pw_we   = 1'b0;
		sc_we   = 1'b0;
		dc_we   = 1'b0;
		iss_v   = 1'b0;
		iss_dec = 1'b0;
		dif_v   = 1'b0;
		emit_v  = 1'b0;
		st_ra   = row_f1_q;
		nd_ra   = j_q;
		unique case (state_q)
			tme_pkg::ST_IDLE: begin
				if (nonempty) begin
					pop = 1'b1;
					case (head.op)
						tme_pkg::OP_POWER:  pw_we = 1'b1;
						tme_pkg::OP_STEADY: sc_we = 1'b1;
						tme_pkg::OP_DECAY:  dc_we = 1'b1;
						default: begin
						end
					endcase
				end
			end
			tme_pkg::ST_STEADY: iss_v = 1'b1;
			tme_pkg::ST_DIFF: begin
				dif_v = 1'b1;
				st_ra = j_q;
			end
			tme_pkg::ST_DECAY: begin
				iss_v   = 1'b1;
				iss_dec = 1'b1;
			end
			tme_pkg::ST_EMIT: begin
				emit_v = 1'b1;
				nd_ra  = NODE_AW'(w_sub);
			end
			default: begin
			end
		endcase
		iss_first = (j_q == '0);
		iss_last  = row_end;
	end

	// operand select and finalize
	always_comb begin
		coef      = dec_s1 ? dc_rd : sc_rd;
		opnd      = dec_s1 ? {df_rd[31], df_rd} : {1'b0, pw_rd};
		acc_sum   = first_s3 ? prod_s3 : acc_q + prod_s3;
		steady_fl = sat32(res_f2_q[ACC_W-1:24]);
		decay_fl  = sat32(64'($signed(res_f2_q[ACC_W-1:46])));
		st_we     = fin2_q && !dec_f2_q;
		st_wa     = row_f2_q;
		st_wd     = sat32(64'(34'(steady_fl) + amb));
		nd_we     = fin2_q && dec_f2_q;
		nd_wa     = row_f2_q;
		nd_wd     = sat32(64'(34'($signed(st_rd)) + 34'(decay_fl)));
		df_we     = dv_s1;
		df_wd     = sat32(64'(34'(node_val) - 34'($signed(st_rd))));
		centi_q   = 40'(node_val) * 40'sd100;
		centi_r   = (centi_q >= 0) ? (centi_q >>> 16) : -((-centi_q) >>> 16);
		if (w_s1 == PKT_W'(0)) begin
			word_n = {16'd0, master_address};
		end else if (w_s1 == PKT_W'(1)) begin
			word_n = 32'(CELLS + 11);
		end else if (w_s1 == PKT_W'(2)) begin
			word_n = {24'd0, packet_kind};
		end else if (w_s1 < PKT_W'(tme_pkg::HDR_WORDS)) begin
			word_n = '0;
		end else begin
			word_n = centi_r[31:0];
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		amb_prod_q <= 61'({ambient, 14'd0}) * 61'(tme_pkg::AMB_RECIP);
		nd_ra_s1   <= nd_ra;
		row_s1     <= i_q;
		first_s1   <= iss_first;
		last_s1    <= iss_last;
		dec_s1     <= iss_dec;
		plo_s2     <= coef * $signed({1'b0, opnd[15:0]});
		phi_s2     <= coef * $signed(opnd[32:16]);
		row_s2     <= row_s1;
		first_s2   <= first_s1;
		last_s2    <= last_s1;
		dec_s2     <= dec_s1;
		prod_s3    <= ACC_W'(plo_s2) + (ACC_W'(phi_s2) <<< 16);
		row_s3     <= row_s2;
		first_s3   <= first_s2;
		last_s3    <= last_s2;
		dec_s3     <= dec_s2;
		if (v_s3) begin
			acc_q <= acc_sum;
		end
		if (v_s3 && last_s3) begin
			res_f1_q <= acc_sum;
			row_f1_q <= row_s3;
			dec_f1_q <= dec_s3;
		end
		res_f2_q <= res_f1_q;
		row_f2_q <= row_f1_q;
		dec_f2_q <= dec_f1_q;
		dj_s1    <= j_q;
		w_s1     <= w_q;
		packet_word <= word_n;
		last_word   <= ev_s1 && (w_s1 == PKT_W'(PKT - 1));
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= tme_pkg::ST_IDLE;
			i_q         <= '0;
			j_q         <= '0;
			caddr_q     <= '0;
			w_q         <= '0;
			v_s1        <= 1'b0;
			v_s2        <= 1'b0;
			v_s3        <= 1'b0;
			fin1_q      <= 1'b0;
			fin2_q      <= 1'b0;
			dv_s1       <= 1'b0;
			ev_s1       <= 1'b0;
			word_strobe <= 1'b0;
			nd_vld_q    <= '0;
		end else begin
			state_q     <= state_n;
			v_s1        <= iss_v;
			v_s2        <= v_s1;
			v_s3        <= v_s2;
			fin1_q      <= v_s3 && last_s3;
			fin2_q      <= fin1_q;
			dv_s1       <= dif_v;
			ev_s1       <= emit_v;
			word_strobe <= ev_s1;
			if (nd_we) begin
				nd_vld_q[nd_wa] <= 1'b1;
			end
			if (iss_v) begin
				caddr_q <= caddr_q + DC_AW'(1);
				if (row_end) begin
					j_q <= '0;
					i_q <= i_q + NODE_AW'(1);
				end else begin
					j_q <= j_q + NODE_AW'(1);
				end
			end else if (dif_v) begin
				j_q <= j_q + NODE_AW'(1);
			end else if (emit_v) begin
				w_q <= w_q + PKT_W'(1);
			end else begin
				i_q     <= '0;
				j_q     <= '0;
				caddr_q <= '0;
				w_q     <= '0;
			end
		end
	end

endmodule

@@ rtl/thermal_matrix_estimator_core.sv @@
// ----------------------------------------------------------------------------
// thermal_matrix_estimator_core
// grid power collection and matrix exponential thermal step
// ----------------------------------------------------------------------------
// An item is taken whenever start is high and busy is low. Network flits and
// coefficient loads are classified by the front end in the cycle they arrive
// and queued for the back end; busy rises only when the two entry queue is
// full, so a burst of items runs at one per cycle until the back end falls
// behind. Coefficient and power writes retire while the back end is idle,
// one per cycle. A completing flit starts a model step on the single shared
// multiply-accumulate unit: NODES*CELLS steady products, a difference pass
// over all NODES nodes, then NODES*NODES decay products, one product per
// cycle, each product pass followed by a pipeline drain (with NODES =
// 4*CELLS+12). The temperature packet of CELLS+13 words then leaves on
// consecutive cycles, one word per word_strobe pulse. The receiver
// cannot stall: a word is present for exactly one cycle. Node temperatures
// come out of reset at 313.15 kelvin through per-node valid bits, so no
// clearing pass is needed.
// ----------------------------------------------------------------------------
module thermal_matrix_estimator_core #(
	parameter int GRID_X = tme_pkg::GRID_X_DEF,
	parameter int GRID_Y = tme_pkg::GRID_Y_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	// item channel
	input  logic                        start,
	output logic                        busy,
	input  logic [1:0]                  func,
	input  logic [31:0]                 flit_word,
	input  logic [7:0]                  coeff_row,
	input  logic [7:0]                  coeff_col,
	input  logic signed [47:0]          coeff_value,
	// result channel
	output logic                        word_strobe,
	output logic [31:0]                 packet_word,
	output logic                        last_word,
	// apb configuration port
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [tme_pkg::PADDR_W-1:0] paddr,
	input  logic [31:0]                 pwdata,
	output logic [31:0]                 prdata,
	output logic                        pready
);

	logic [15:0]   ambient_q;
	logic [15:0]   master_q;
	logic [7:0]    kind_q;
	logic          accept;
	logic          push, pop, nonempty, full;
	tme_pkg::cmd_t push_cmd, head;

	// an item enters while the queue has room
	assign busy   = full;
	assign accept = start && !busy;
	assign pready = 1'b1;

	// register read mux
	always_comb begin
		unique case (paddr[3:2])
			tme_pkg::REG_AMBIENT: prdata = {16'd0, ambient_q};
			tme_pkg::REG_MASTER:  prdata = {16'd0, master_q};
			tme_pkg::REG_KIND:    prdata = {24'd0, kind_q};
			default:              prdata = '0;
		endcase
	end

	// register write on the access phase
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ambient_q <= tme_pkg::AMBIENT_RST;
			master_q  <= tme_pkg::MASTER_RST;
			kind_q    <= tme_pkg::KIND_RST;
		end else if (psel && penable && pwrite) begin
			case (paddr[3:2])
				tme_pkg::REG_AMBIENT: ambient_q <= pwdata[15:0];
				tme_pkg::REG_MASTER:  master_q  <= pwdata[15:0];
				tme_pkg::REG_KIND:    kind_q    <= pwdata[7:0];
				default: begin
				end
			endcase
		end
	end

	// flit tracking, completion detection, command build
	tme_front #(.GRID_X(GRID_X), .GRID_Y(GRID_Y)) u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.accept      (accept),
		.func        (func),
		.flit_word   (flit_word),
		.coeff_row   (coeff_row),
		.coeff_col   (coeff_col),
		.coeff_value (coeff_value),
		.push        (push),
		.cmd         (push_cmd)
	);

	// decouples flit intake from the long model step
	tme_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_cmd (push_cmd),
		.pop      (pop),
		.head     (head),
		.nonempty (nonempty),
		.full     (full)
	);

	// storage, mac engine and packet words
	tme_back #(.GRID_X(GRID_X), .GRID_Y(GRID_Y)) u_back (
		.clk            (clk),
		.arst_n         (arst_n),
		.head           (head),
		.nonempty       (nonempty),
		.pop            (pop),
		.ambient        (ambient_q),
		.master_address (master_q),
		.packet_kind    (kind_q),
		.word_strobe    (word_strobe),
		.packet_word    (packet_word),
		.last_word      (last_word)
	);

	// last word flag only ever rides on a strobe
	a_last_strobe: assert property (@(posedge clk) disable iff (!arst_n)
		last_word |-> word_strobe)
		else $error("last word without strobe");

	// packet words are contiguous up to the last word
	a_contig: assert property (@(posedge clk) disable iff (!arst_n)
		(word_strobe && !last_word) |=> word_strobe)
		else $error("gap inside temperature packet");

	// packets never run back to back
	a_gap: assert property (@(posedge clk) disable iff (!arst_n)
		last_word |=> !word_strobe)
		else $error("strobe right after last word");

	// a packet opens with the master address
	a_head: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(word_strobe) |-> (packet_word == {16'd0, master_q}))
		else $error("packet does not start with master address");

endmodule

@@ tb/thermal_matrix_estimator_core_test.sv @@
// ----------------------------------------------------------------------------
// thermal_matrix_estimator_core_test
// self-checking bench for the grid power collector and thermal step
// ----------------------------------------------------------------------------
// Loads every coefficient, walks a short table of corner items, then streams
// power packets for random grid cells with noise mixed in (coefficient
// reloads, unused commands, stray flits, cells off the grid). A bit-exact
// predictor runs beside the block and every packet word is checked against
// it. Register settings change between phases while the block is idle.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module thermal_matrix_estimator_core_test;

	localparam int CELLS = tme_pkg::GRID_X_DEF * tme_pkg::GRID_Y_DEF;
	localparam int NODES = 4 * CELLS + 12;
	localparam int PKT_WORDS = CELLS + 13;
	localparam int DRAIN_CYCLES = 400;

	typedef logic signed [127:0] wide_t;

	typedef struct packed {
		logic [31:0] word;
		logic        last;
	} pkt_word_t;

	typedef struct {
		tme_pkg::func_t f;
		logic [31:0] flit;
		logic [7:0]  row;
		logic [7:0]  col;
		logic [47:0] value;
		int          n_words;   // words the item must cause
	} stim_row_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        start = 1'b0;
	logic        busy;
	logic [1:0]  func = 2'd0;
	logic [31:0] flit_word = '0;
	logic [7:0]  coeff_row = '0;
	logic [7:0]  coeff_col = '0;
	logic signed [47:0] coeff_value = '0;
	logic        word_strobe;
	logic [31:0] packet_word;
	logic        last_word;
	logic        psel = 1'b0;
	logic        penable = 1'b0;
	logic        pwrite = 1'b0;
	logic [tme_pkg::PADDR_W-1:0] paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic        pready;

	thermal_matrix_estimator_core i_dut (
		.clk(clk), .arst_n(arst_n),
		.start(start), .busy(busy), .func(func), .flit_word(flit_word),
		.coeff_row(coeff_row), .coeff_col(coeff_col), .coeff_value(coeff_value),
		.word_strobe(word_strobe), .packet_word(packet_word), .last_word(last_word),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// model copy: registers
	logic [15:0] m_ambient;
	logic [15:0] m_master;
	logic [7:0]  m_kind;
	// model copy: flit tracking and thermal state
	logic [3:0]  m_count;
	logic [7:0]  m_src_x;
	logic [7:0]  m_src_y;
	logic [31:0] m_power [CELLS];
	logic        m_reported [CELLS];
	logic        m_first_seen;
	logic signed [47:0] m_steady_c [NODES*CELLS];
	logic signed [47:0] m_decay_c [NODES*NODES];
	logic signed [31:0] m_node_t [NODES];
	logic signed [31:0] m_steady_t [NODES];

	pkt_word_t pending_words [$];
	int errors = 0;
	int words_seen = 0;
	int steps_done = 0;
	int items_sent = 0;
	bit no_idle = 1'b0;

	task automatic report(input string msg);
		$display("[%0t] mismatch: %s", $realtime, msg);
		errors++;
	endtask

	function automatic logic signed [31:0] sat32(input wide_t v);
		if (v > wide_t'(64'sd2147483647)) return 32'sh7fffffff;
		if (v < wide_t'(-64'sd2147483648)) return 32'sh80000000;
		return v[31:0];
	endfunction

	// one matrix exponential step over the whole node set
	task automatic advance_thermal_model();
		wide_t acc, a, b, amb, t;
		logic signed [31:0] diff [NODES];
		logic signed [31:0] s;
		amb = (wide_t'({112'b0, m_ambient}) * 65536) / 100;
		for (int i = 0; i < NODES; i++) begin
			acc = '0;
			for (int j = 0; j < CELLS; j++) begin
				a = m_steady_c[i*CELLS+j];
				b = {96'b0, m_power[j]};
				acc += a * b;
			end
			s = sat32(acc >>> 24);
			t = s;
			m_steady_t[i] = sat32(t + amb);
		end
		for (int j = 0; j < NODES; j++) begin
			a = m_node_t[j];
			b = m_steady_t[j];
			diff[j] = sat32(a - b);
		end
		for (int i = 0; i < NODES; i++) begin
			acc = '0;
			for (int j = 0; j < NODES; j++) begin
				a = m_decay_c[i*NODES+j];
				b = diff[j];
				acc += a * b;
			end
			s = sat32(acc >>> 46);
			a = s;
			b = m_steady_t[i];
			m_node_t[i] = sat32(a + b);
		end
	endtask

	// temperature in hundredths of kelvin, truncated toward zero
	function automatic logic [31:0] centi_kelvin(input logic signed [31:0] t);
		longint q;
		q = longint'(t) * 100;
		q = q / 65536;
		return q[31:0];
	endfunction

	// advances the model by one accepted item, queues the words it causes
	task automatic apply_item(input tme_pkg::func_t f, input logic [31:0] fw,
			input logic [7:0] r, input logic [7:0] c, input logic [47:0] v);
		bit all_in;
		pkt_word_t pw;
		if (f == tme_pkg::FUNC_STEADY) begin
			if (r < NODES && c < CELLS) m_steady_c[r*CELLS+c] = v;
			return;
		end
		if (f == tme_pkg::FUNC_DECAY) begin
			if (r < NODES && c < NODES) m_decay_c[r*NODES+c] = v;
			return;
		end
		if (f != tme_pkg::FUNC_FLIT) return;
		m_count = m_count + 4'd1;
		if (m_count == tme_pkg::FLIT_CLR) begin
			m_src_x = '0;
			m_src_y = '0;
		end else if (m_count == tme_pkg::FLIT_SRC) begin
			m_src_x = fw[15:8];
			m_src_y = fw[7:0];
		end else if (m_count == tme_pkg::FLIT_PWR) begin
			// power from a cell off the grid is dropped
			if (m_src_x < tme_pkg::GRID_X_DEF && m_src_y < tme_pkg::GRID_Y_DEF) begin
				m_power[m_src_y*tme_pkg::GRID_X_DEF+m_src_x] = fw;
				m_reported[m_src_y*tme_pkg::GRID_X_DEF+m_src_x] = 1'b1;
			end
		end else if (m_count >= tme_pkg::FLIT_END) begin
			m_count = '0;
		end
		all_in = 1'b1;
		for (int i = 0; i < CELLS; i++) if (!m_reported[i]) all_in = 1'b0;
		if (!all_in) return;
		// the very first full set only arms the step, next flit fires it
		if (!m_first_seen) begin
			m_first_seen = 1'b1;
			return;
		end
		for (int i = 0; i < CELLS; i++) m_reported[i] = 1'b0;
		advance_thermal_model();
		m_src_x = '0;
		m_src_y = '0;
		steps_done++;
		for (int i = 0; i < PKT_WORDS; i++) begin
			pw.last = (i == PKT_WORDS - 1);
			if (i == 0) pw.word = {16'b0, m_master};
			else if (i == 1) pw.word = CELLS + 11;
			else if (i == 2) pw.word = {24'b0, m_kind};
			else if (i >= tme_pkg::HDR_WORDS)
				pw.word = centi_kelvin(m_node_t[i-tme_pkg::HDR_WORDS]);
			else pw.word = '0;
			pending_words.push_back(pw);
		end
	endtask

	// drive one item, hold it until busy lets it through at a clock edge
	task automatic send_item(input tme_pkg::func_t f, input logic [31:0] fw,
			input logic [7:0] r, input logic [7:0] c, input logic [47:0] v);
		int gap;
		bit took;
		gap = 0;
		if (!no_idle) while ($urandom_range(0, 99) < 26) gap++;
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start <= 1'b1;
		func <= f;
		flit_word <= fw;
		coeff_row <= r;
		coeff_col <= c;
		coeff_value <= v;
		forever begin
			@(negedge clk);
			took = !busy;
			@(posedge clk);
			if (took) break;
		end
		apply_item(f, fw, r, c, v);
		items_sent++;
	endtask

	task automatic apb_write(input logic [1:0] idx, input logic [31:0] data);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= tme_pkg::PADDR_W'(idx) << 2;
		pwdata <= data;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		penable <= 1'b0;
		pwrite <= 1'b0;
		if (idx == tme_pkg::REG_AMBIENT) m_ambient = data[15:0];
		else if (idx == tme_pkg::REG_MASTER) m_master = data[15:0];
		else if (idx == tme_pkg::REG_KIND) m_kind = data[7:0];
		// read it back, psel stays high into the read setup
		paddr <= tme_pkg::PADDR_W'(idx) << 2;
		@(posedge clk);
		penable <= 1'b1;
		@(negedge clk);
		if (idx == tme_pkg::REG_AMBIENT && prdata[15:0] !== m_ambient)
			report("ambient readback");
		if (idx == tme_pkg::REG_MASTER && prdata[15:0] !== m_master)
			report("master readback");
		if (idx == tme_pkg::REG_KIND && prdata[7:0] !== m_kind)
			report("kind readback");
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
	endtask

	// sender holds off until the last word is out and the back end is quiet
	task automatic drain_block();
		start <= 1'b0;
		@(posedge clk);
		while (pending_words.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// pad with stray flits until the next flit opens a packet
	task automatic realign_flits();
		while (m_count != 4'd0)
			send_item(tme_pkg::FUNC_FLIT, $urandom, '0, '0, '0);
	endtask

	task automatic send_packet(input logic [7:0] x, input logic [7:0] y,
			input logic [31:0] pwr);
		logic [31:0] fw;
		realign_flits();
		for (int k = 1; k <= 13; k++) begin
			fw = $urandom;
			if (k == 4) fw = {fw[31:16], x, y};
			else if (k == 5) fw = pwr;
			send_item(tme_pkg::FUNC_FLIT, fw, '0, '0, '0);
		end
	endtask

	function automatic logic [47:0] rand48();
		return 48'({$urandom, $urandom});
	endfunction

	function automatic logic [31:0] rand_power();
		case ($urandom_range(0, 9))
			0: return 32'h0;
			1: return 32'hffff_ffff;
			default: return $urandom;
		endcase
	endfunction

	// one burst of random traffic, mostly packets for cells still missing
	task automatic random_unit();
		int pick, n_open, sel, cell_pick;
		int open_cells [$];
		pick = $urandom_range(0, 99);
		if (pick < 80) begin
			open_cells.delete();
			for (int i = 0; i < CELLS; i++) if (!m_reported[i]) open_cells.push_back(i);
			n_open = open_cells.size();
			if (n_open == 0) cell_pick = $urandom_range(0, CELLS - 1);
			else begin
				sel = $urandom_range(0, n_open - 1);
				cell_pick = open_cells[sel];
			end
			send_packet(8'(cell_pick % tme_pkg::GRID_X_DEF),
				8'(cell_pick / tme_pkg::GRID_X_DEF), rand_power());
		end else if (pick < 85) begin
			// source off the grid
			if ($urandom_range(0, 1))
				send_packet(8'($urandom_range(tme_pkg::GRID_X_DEF, 255)),
					8'($urandom_range(0, 255)), $urandom);
			else send_packet(8'($urandom_range(0, tme_pkg::GRID_X_DEF - 1)),
					8'($urandom_range(tme_pkg::GRID_Y_DEF, 255)), $urandom);
		end else if (pick < 92) begin
			// coefficient reloads, full range, some indexes off the matrix
			if ($urandom_range(0, 1))
				send_item(tme_pkg::FUNC_STEADY, $urandom, 8'($urandom_range(0, 90)),
					8'($urandom_range(0, 20)), rand48());
			else
				send_item(tme_pkg::FUNC_DECAY, $urandom, 8'($urandom_range(0, 90)),
					8'($urandom_range(0, 90)), rand48());
		end else if (pick < 95) begin
			send_item(tme_pkg::FUNC_NONE, $urandom, 8'($urandom), 8'($urandom), rand48());
		end else begin
			// broken sequence: stray flits shift the packet phase
			repeat ($urandom_range(1, 3))
				send_item(tme_pkg::FUNC_FLIT, $urandom, '0, '0, '0);
		end
	endtask

	// result side: the block never waits, so sample every strobed word
	always @(negedge clk) begin
		pkt_word_t want;
		if (arst_n && word_strobe) begin
			words_seen++;
			if (pending_words.size() == 0) report($sformatf("unexpected word %h", packet_word));
			else begin
				want = pending_words.pop_front();
				if (packet_word !== want.word)
					report($sformatf("packet_word got %h want %h", packet_word, want.word));
				if (last_word !== want.last)
					report($sformatf("last_word got %b want %b", last_word, want.last));
			end
		end
	end

	// overall run limit
	initial begin
		#3000000;
		$display("Verification failed");
		$finish;
	end

	stim_row_t corner_rows [$];

	initial begin
		int target;
		logic signed [47:0] v;
		m_ambient = tme_pkg::AMBIENT_RST;
		m_master = tme_pkg::MASTER_RST;
		m_kind = tme_pkg::KIND_RST;
		m_count = '0;
		m_src_x = '0;
		m_src_y = '0;
		m_first_seen = 1'b0;
		for (int i = 0; i < CELLS; i++) begin
			m_power[i] = '0;
			m_reported[i] = 1'b0;
		end
		for (int i = 0; i < NODES; i++) begin
			m_node_t[i] = tme_pkg::NODE_RESET;
			m_steady_t[i] = '0;
		end

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// fill both matrices so no unwritten entry is ever read
		for (int r = 0; r < NODES; r++)
			for (int c = 0; c < CELLS; c++) begin
				v = $signed(48'($urandom_range(0, 1 << 21))) - (1 << 19);
				send_item(tme_pkg::FUNC_STEADY, '0, 8'(r), 8'(c), v);
			end
		for (int r = 0; r < NODES; r++)
			for (int c = 0; c < NODES; c++) begin
				v = $signed(48'($urandom_range(0, 1 << 30))) - (1 << 28);
				if (r == c) v = v + (48'sd1 <<< 45);
				send_item(tme_pkg::FUNC_DECAY, '0, 8'(r), 8'(c), v);
			end

		// corner items: unused command, indexes off the matrix, extreme values,
		// and one packet from a cell off the grid with an all-ones power word
		corner_rows = '{
			'{tme_pkg::FUNC_NONE,   32'hffff_ffff, 8'hff, 8'hff, 48'hffff_ffff_ffff, 0},
			'{tme_pkg::FUNC_STEADY, 32'h0, 8'd76,  8'd0,  48'h7fff_ffff_ffff, 0},
			'{tme_pkg::FUNC_STEADY, 32'h0, 8'd0,   8'd16, 48'h8000_0000_0000, 0},
			'{tme_pkg::FUNC_DECAY,  32'h0, 8'd255, 8'd0,  48'h7fff_ffff_ffff, 0},
			'{tme_pkg::FUNC_DECAY,  32'h0, 8'd0,   8'd76, 48'h8000_0000_0000, 0},
			'{tme_pkg::FUNC_STEADY, 32'h0, 8'd75,  8'd15, 48'h0000_0000_0000, 0},
			'{tme_pkg::FUNC_DECAY,  32'h0, 8'd75,  8'd75, 48'h0000_0000_0001, 0},
			'{tme_pkg::FUNC_FLIT,   32'hffff_ffff, 8'h0, 8'h0, 48'h0, 0},
			'{tme_pkg::FUNC_FLIT,   32'h0000_0000, 8'h0, 8'h0, 48'h0, 0},
			'{tme_pkg::FUNC_FLIT,   32'hffff_ffff, 8'h0, 8'h0, 48'h0, 0},
			'{tme_pkg::FUNC_FLIT,   32'h0000_ff00, 8'h0, 8'h0, 48'h0, 0},
			'{tme_pkg::FUNC_FLIT,   32'hffff_ffff, 8'h0, 8'h0, 48'h0, 0},
			'{tme_pkg::FUNC_FLIT,   32'h0, 8'h0, 8'h0, 48'h0, 0},
			'{tme_pkg::FUNC_FLIT,   32'h0, 8'h0, 8'h0, 48'h0, 0},
			'{tme_pkg::FUNC_FLIT,   32'h0, 8'h0, 8'h0, 48'h0, 0},
			'{tme_pkg::FUNC_FLIT,   32'h0, 8'h0, 8'h0, 48'h0, 0},
			'{tme_pkg::FUNC_FLIT,   32'h0, 8'h0, 8'h0, 48'h0, 0},
			'{tme_pkg::FUNC_FLIT,   32'h0, 8'h0, 8'h0, 48'h0, 0},
			'{tme_pkg::FUNC_FLIT,   32'h0, 8'h0, 8'h0, 48'h0, 0},
			'{tme_pkg::FUNC_FLIT,   32'h0, 8'h0, 8'h0, 48'h0, 0}
		};
		foreach (corner_rows[k]) begin
			target = pending_words.size();
			send_item(corner_rows[k].f, corner_rows[k].flit, corner_rows[k].row,
				corner_rows[k].col, corner_rows[k].value);
			if (pending_words.size() - target != corner_rows[k].n_words)
				report($sformatf("corner row %0d word count", k));
		end

		// phases: reset settings, all zero (no idling), all ones, random
		for (int phase = 0; phase < 4; phase++) begin
			if (phase > 0) begin
				drain_block();
				case (phase)
					1: begin
						apb_write(tme_pkg::REG_AMBIENT, 32'h0);
						apb_write(tme_pkg::REG_MASTER, 32'h0);
						apb_write(tme_pkg::REG_KIND, 32'h0);
					end
					2: begin
						apb_write(tme_pkg::REG_AMBIENT, 32'hffff_ffff);
						apb_write(tme_pkg::REG_MASTER, 32'h0000_ffff);
						apb_write(tme_pkg::REG_KIND, 32'hffff_ffff);
					end
					default: begin
						apb_write(tme_pkg::REG_AMBIENT, $urandom);
						apb_write(tme_pkg::REG_MASTER, $urandom);
						apb_write(tme_pkg::REG_KIND, $urandom);
					end
				endcase
			end
			no_idle = (phase == 1);
			target = steps_done + 1;
			while (steps_done < target) random_unit();
			// a few items past the step land while the block is computing
			repeat ($urandom_range(2, 8)) random_unit();
		end
		no_idle = 1'b0;

		drain_block();
		$display("run covered %0d items and %0d thermal steps, %0d packet words checked",
			items_sent, steps_done, words_seen);
		$display("register settings: reset values, all zero, all ones, random");
		if (errors == 0 && pending_words.size() == 0) begin
			$display("Verification passed");
		end else begin
			$display("Verification failed");
		end
		$finish;
	end

endmodule
